[hw/rtl/gray_png_stored_stream_writer_macros.svh]
// Assertion macros shared by the checker of the PNG stream writer.
`ifndef GRAY_PNG_STORED_STREAM_WRITER_MACROS_SVH
`define GRAY_PNG_STORED_STREAM_WRITER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define GPSW_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define GPSW_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define GPSW_ASSERT_NEXT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[hw/rtl/gpsw_pkg.sv]
// Shared types, constants and the CRC-32 byte update of the PNG stream writer.
`timescale 1ns / 1ps
package gpsw_pkg;
  typedef logic [7:0] byte_t;

  localparam int BLOCK_MAX_DEF = 65535;
  localparam int STEP_MAX = 50;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  function automatic logic [31:0] crc_byte(logic [31:0] c_in, byte_t b);
    logic [31:0] c;
    c = c_in ^ {24'b0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction
endpackage

[hw/rtl/gpsw_stream_if.sv]
// Valid/ready stream interfaces for pixel beats and PNG byte beats.
`timescale 1ns / 1ps
interface gpsw_pixel_if;
  import gpsw_pkg::*;
  logic valid;
  logic ready;
  byte_t pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface gpsw_byte_if;
  import gpsw_pkg::*;
  logic valid;
  logic ready;
  byte_t out_byte;
  logic run_last;
  logic file_end;
  modport source (output valid, output out_byte, output run_last, output file_end, input ready);
  modport sink (input valid, input out_byte, input run_last, input file_end, output ready);
endinterface

[hw/rtl/gray_png_stored_stream_writer.sv]
// PNG writer for 8-bit gray images using stored deflate blocks, one byte beat per cycle while the sink is ready.
`timescale 1ns / 1ps
// The block turns a raster stream of gray pixels into the bytes of a PNG file, one output
// byte per clock while the sink is ready. A pixel inside a row yields one data byte, the first
// pixel of a row two (filter byte), plus five block header bytes whenever a new block starts.
// The first pixel of an image emits 43 header bytes. The IDAT length comes from a multiplier
// and a reciprocal multiplication by the block size that finish within the first few header
// bytes, so the header does not stall. The last pixel adds 20 trailer bytes. A pixel is
// buffered one deep, so the next pixel is taken while the current one is still producing
// bytes. At most 50 byte beats belong to one pixel; the rest follow after the next pixel
// arrives. Width and height are sampled when an image starts; zero is treated as one.
module gray_png_stored_stream_writer #(
  parameter int BLOCK_MAX = gpsw_pkg::BLOCK_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  gpsw_pixel_if.sink         pix,
  gpsw_byte_if.source        bytes,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gpsw_pkg::*;

  localparam logic [15:0] BM = 16'(BLOCK_MAX);
  localparam logic [5:0] STEP_LAST = 6'(STEP_MAX - 1);
  localparam int RECIP_SHIFT = 32 + $clog2(BLOCK_MAX);
  localparam logic [32:0] RECIP =
    33'(((64'd1 << RECIP_SHIFT) + 64'(BLOCK_MAX) - 64'd1) / 64'(BLOCK_MAX));
  localparam logic [15:0] RECIP_LO = RECIP[15:0];
  localparam logic [16:0] RECIP_HI = RECIP[32:16];

  typedef enum logic [2:0] {P_IDLE, P_HDR, P_BH, P_DATA, P_FIN} phase_t;
  typedef enum logic [2:0] {C_IDLE, C_MUL, C_PREP, C_PROD, C_SUM, C_LEN, C_DONE} cstate_t;

  logic [15:0] cfg_w, cfg_h, img_w, img_h;
  logic pend_v, qv, filt, paused, header_done, ov, orl, ofe;
  byte_t pend_px, qpx, px, obyte;
  phase_t phase;
  logic [5:0] idx, step_cnt;
  logic [16:0] col;
  logic [15:0] row, block_left, adler_lo, adler_hi;
  logic [31:0] remaining, crc, cword, raw, quo, idat_len, num;
  logic [47:0] plo;
  logic [48:0] phi;
  cstate_t cstate;

  logic [15:0] cfg_w_next, cfg_h_next, img_w_next, img_h_next;
  logic pend_v_next, qv_next, filt_next, paused_next, header_done_next, ov_next;
  byte_t pend_px_next, qpx_next, px_next;
  phase_t phase_next;
  logic [5:0] idx_next, step_cnt_next;
  logic [16:0] col_next;
  logic [15:0] row_next, block_left_next, adler_lo_next, adler_hi_next;
  logic [31:0] remaining_next, crc_next, cword_next, raw_next, quo_next, idat_len_next;
  logic [31:0] num_next;
  logic [47:0] plo_next;
  logic [48:0] phi_next;
  cstate_t cstate_next;

  logic stall_len, fire, pend_take, start_req, job_last, fin_end, fin_go, row_end, rl;
  byte_t b, start_px;
  logic [15:0] blen;
  logic [16:0] lo_s, lo_m, hi_s, hi_m;
  logic [64:0] psum;
  logic tag_first;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {16'b0, cfg_h} : {16'b0, cfg_w};

  assign stall_len = (phase == P_HDR) && (idx == 6'd33) && (cstate != C_DONE);
  assign fire = (phase != P_IDLE) && !paused && !stall_len && (!ov || bytes.ready);
  assign blen = (remaining > {16'b0, BM}) ? BM : remaining[15:0];
  assign row_end = (col == {1'b0, img_w});
  assign fin_go = !filt && row_end && ((17'(row) + 17'd1) == {1'b0, img_h});
  assign fin_end = (phase == P_FIN) && (idx == 6'd19);
  assign job_last = ((phase == P_DATA) && !filt && !fin_go) || fin_end;
  assign tag_first = ((phase == P_HDR) && ((idx == 6'd12) || (idx == 6'd37))) ||
                     ((phase == P_FIN) && (idx == 6'd12));

  assign lo_s = {1'b0, adler_lo} + {9'b0, b};
  assign lo_m = (lo_s >= ADLER_MOD) ? (lo_s - ADLER_MOD) : lo_s;
  assign hi_s = {1'b0, adler_hi} + lo_m;
  assign hi_m = (hi_s >= ADLER_MOD) ? (hi_s - ADLER_MOD) : hi_s;
  assign psum = {phi, 16'b0} + {17'b0, plo};

  always_comb begin
    b = 8'h00;
    unique case (phase)
      P_HDR: begin
        unique case (idx)
          6'd0: b = 8'h89;
          6'd1: b = 8'h50;
          6'd2: b = 8'h4E;
          6'd3: b = 8'h47;
          6'd4: b = 8'h0D;
          6'd5: b = 8'h0A;
          6'd6: b = 8'h1A;
          6'd7: b = 8'h0A;
          6'd11: b = 8'h0D;
          6'd12: b = 8'h49;
          6'd13: b = 8'h48;
          6'd14: b = 8'h44;
          6'd15: b = 8'h52;
          6'd18: b = img_w[15:8];
          6'd19: b = img_w[7:0];
          6'd22: b = img_h[15:8];
          6'd23: b = img_h[7:0];
          6'd24: b = 8'h08;
          6'd29: b = ~crc[31:24];
          6'd30: b = cword[23:16];
          6'd31: b = cword[15:8];
          6'd32: b = cword[7:0];
          6'd33: b = idat_len[31:24];
          6'd34: b = idat_len[23:16];
          6'd35: b = idat_len[15:8];
          6'd36: b = idat_len[7:0];
          6'd37: b = 8'h49;
          6'd38: b = 8'h44;
          6'd39: b = 8'h41;
          6'd40: b = 8'h54;
          6'd41: b = 8'h78;
          6'd42: b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      P_BH: begin
        unique case (idx)
          6'd0: b = {7'b0, remaining <= {16'b0, BM}};
          6'd1: b = blen[7:0];
          6'd2: b = blen[15:8];
          6'd3: b = ~blen[7:0];
          6'd4: b = ~blen[15:8];
          default: b = 8'h00;
        endcase
      end
      P_DATA: b = filt ? 8'h00 : px;
      P_FIN: begin
        unique case (idx)
          6'd0: b = adler_hi[15:8];
          6'd1: b = adler_hi[7:0];
          6'd2: b = adler_lo[15:8];
          6'd3: b = adler_lo[7:0];
          6'd4, 6'd16: b = ~crc[31:24];
          6'd5, 6'd17: b = cword[23:16];
          6'd6, 6'd18: b = cword[15:8];
          6'd7, 6'd19: b = cword[7:0];
          6'd12: b = 8'h49;
          6'd13: b = 8'h45;
          6'd14: b = 8'h4E;
          6'd15: b = 8'h44;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
  end

  always_comb begin
    cfg_w_next = cfg_w;
    cfg_h_next = cfg_h;
    img_w_next = img_w;
    img_h_next = img_h;
    pend_v_next = pend_v;
    pend_px_next = pend_px;
    qv_next = qv;
    qpx_next = qpx;
    px_next = px;
    filt_next = filt;
    paused_next = paused;
    header_done_next = header_done;
    phase_next = phase;
    idx_next = idx;
    step_cnt_next = step_cnt;
    col_next = col;
    row_next = row;
    block_left_next = block_left;
    adler_lo_next = adler_lo;
    adler_hi_next = adler_hi;
    remaining_next = remaining;
    crc_next = crc;
    cword_next = cword;
    cstate_next = cstate;
    raw_next = raw;
    num_next = num;
    plo_next = plo;
    phi_next = phi;
    quo_next = quo;
    idat_len_next = idat_len;
    ov_next = ov;
    pend_take = 1'b0;
    start_req = 1'b0;
    start_px = pend_px;
    rl = 1'b0;

    if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        cfg_h_next = pwdata[15:0];
      end else begin
        cfg_w_next = pwdata[15:0];
      end
    end

    unique case (cstate)
      C_MUL: begin
        raw_next = ({16'b0, img_w} + 32'd1) * {16'b0, img_h};
        cstate_next = C_PREP;
      end
      C_PREP: begin
        num_next = 32'({1'b0, raw} + {17'b0, BM} - 33'd1);
        remaining_next = raw;
        cstate_next = C_PROD;
      end
      C_PROD: begin
        plo_next = {16'b0, num} * {32'b0, RECIP_LO};
        phi_next = {17'b0, num} * {32'b0, RECIP_HI};
        cstate_next = C_SUM;
      end
      C_SUM: begin
        quo_next = 32'(psum >> RECIP_SHIFT);
        cstate_next = C_LEN;
      end
      C_LEN: begin
        idat_len_next = raw + 32'd6 + {quo[29:0], 2'b00} + quo;
        cstate_next = C_DONE;
      end
      default: cstate_next = cstate;
    endcase

    if (fire) begin
      ov_next = 1'b1;
      step_cnt_next = step_cnt + 6'd1;
      crc_next = crc_byte(tag_first ? 32'hFFFFFFFF : crc, b);
      if (((phase == P_HDR) && (idx == 6'd29)) ||
          ((phase == P_FIN) && ((idx == 6'd4) || (idx == 6'd16)))) begin
        cword_next = ~crc;
      end
      unique case (phase)
        P_HDR: begin
          if (idx == 6'd42) begin
            phase_next = P_BH;
            idx_next = 6'd0;
          end else begin
            idx_next = idx + 6'd1;
          end
        end
        P_BH: begin
          if (idx == 6'd4) begin
            phase_next = P_DATA;
            block_left_next = blen;
            idx_next = 6'd0;
          end else begin
            idx_next = idx + 6'd1;
          end
        end
        P_DATA: begin
          block_left_next = block_left - 16'd1;
          remaining_next = remaining - 32'd1;
          adler_lo_next = lo_m[15:0];
          adler_hi_next = hi_m[15:0];
          idx_next = 6'd0;
          if (filt) begin
            filt_next = 1'b0;
            col_next = 17'd1;
            phase_next = (block_left == 16'd1) ? P_BH : P_DATA;
          end else if (row_end) begin
            col_next = 17'd0;
            row_next = row + 16'd1;
            if (fin_go) begin
              phase_next = P_FIN;
            end
          end else begin
            col_next = col + 17'd1;
          end
        end
        P_FIN: begin
          idx_next = idx + 6'd1;
          if (fin_end) begin
            header_done_next = 1'b0;
          end
        end
        default: phase_next = phase;
      endcase

      if (job_last) begin
        rl = !(qv && !fin_end) || (step_cnt == STEP_LAST);
        if (qv && !fin_end) begin
          start_req = 1'b1;
          start_px = qpx;
          qv_next = 1'b0;
          if (step_cnt == STEP_LAST) begin
            paused_next = 1'b1;
          end
        end else begin
          qv_next = 1'b0;
          if (pend_v) begin
            start_req = 1'b1;
            pend_take = 1'b1;
            step_cnt_next = 6'd0;
          end else begin
            phase_next = P_IDLE;
          end
        end
      end else if (step_cnt == STEP_LAST) begin
        rl = 1'b1;
        paused_next = 1'b1;
      end
    end else begin
      if (bytes.ready) begin
        ov_next = 1'b0;
      end
      if ((phase == P_IDLE) && pend_v) begin
        start_req = 1'b1;
        pend_take = 1'b1;
        step_cnt_next = 6'd0;
      end else if (paused && pend_v) begin
        paused_next = 1'b0;
        step_cnt_next = 6'd0;
        qv_next = 1'b1;
        qpx_next = pend_px;
        pend_take = 1'b1;
      end
    end

    if (start_req) begin
      px_next = start_px;
      idx_next = 6'd0;
      if (!header_done_next) begin
        header_done_next = 1'b1;
        img_w_next = (cfg_w == 16'd0) ? 16'd1 : cfg_w;
        img_h_next = (cfg_h == 16'd0) ? 16'd1 : cfg_h;
        col_next = 17'd0;
        row_next = 16'd0;
        block_left_next = 16'd0;
        adler_lo_next = 16'd1;
        adler_hi_next = 16'd0;
        cstate_next = C_MUL;
        phase_next = P_HDR;
        filt_next = 1'b1;
      end else begin
        filt_next = (col_next == 17'd0);
        phase_next = (block_left_next == 16'd0) ? P_BH : P_DATA;
      end
    end

    pend_v_next = (pend_v && !pend_take) || (pix.valid && pix.ready);
    if (pix.valid && pix.ready) begin
      pend_px_next = pix.pixel;
    end
  end

  assign pix.ready = !pend_v || pend_take;
  assign bytes.valid = ov;
  assign bytes.out_byte = obyte;
  assign bytes.run_last = orl;
  assign bytes.file_end = ofe;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= 16'd1;
      cfg_h <= 16'd1;
      img_w <= 16'd1;
      img_h <= 16'd1;
      pend_v <= 1'b0;
      qv <= 1'b0;
      filt <= 1'b0;
      paused <= 1'b0;
      header_done <= 1'b0;
      phase <= P_IDLE;
      idx <= 6'd0;
      step_cnt <= 6'd0;
      col <= 17'd0;
      row <= 16'd0;
      block_left <= 16'd0;
      adler_lo <= 16'd1;
      adler_hi <= 16'd0;
      crc <= 32'hFFFFFFFF;
      cstate <= C_IDLE;
      ov <= 1'b0;
    end else begin
      cfg_w <= cfg_w_next;
      cfg_h <= cfg_h_next;
      img_w <= img_w_next;
      img_h <= img_h_next;
      pend_v <= pend_v_next;
      qv <= qv_next;
      filt <= filt_next;
      paused <= paused_next;
      header_done <= header_done_next;
      phase <= phase_next;
      idx <= idx_next;
      step_cnt <= step_cnt_next;
      col <= col_next;
      row <= row_next;
      block_left <= block_left_next;
      adler_lo <= adler_lo_next;
      adler_hi <= adler_hi_next;
      crc <= crc_next;
      cstate <= cstate_next;
      ov <= ov_next;
    end
    pend_px <= pend_px_next;
    qpx <= qpx_next;
    px <= px_next;
    remaining <= remaining_next;
    cword <= cword_next;
    raw <= raw_next;
    num <= num_next;
    plo <= plo_next;
    phi <= phi_next;
    quo <= quo_next;
    idat_len <= idat_len_next;
    if (fire) begin
      obyte <= b;
      orl <= rl;
      ofe <= fin_end;
    end
  end
endmodule

[hw/rtl/gpsw_checker.sv]
// Port-level assertions for the PNG stream writer and the bind that attaches them.
`timescale 1ns / 1ps
`include "gray_png_stored_stream_writer_macros.svh"
module gpsw_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       file_end,
  input logic       pready
);
  `GPSW_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last) && $stable(file_end))
  `GPSW_ASSERT_IMPLY(a_end_closes_run, clk, rst, out_valid && file_end, run_last)
  `GPSW_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !out_valid)
  `GPSW_ASSERT_IMPLY(a_pready_high, clk, rst, 1'b1, pready)
endmodule

bind gray_png_stored_stream_writer gpsw_checker u_gpsw_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(bytes.valid),
  .out_ready(bytes.ready),
  .out_byte(bytes.out_byte),
  .run_last(bytes.run_last),
  .file_end(bytes.file_end),
  .pready(pready)
);

[verif/gray_png_stored_stream_writer_tb.sv]
// Self-checking testbench that predicts the PNG byte stream of the gray PNG writer.
`timescale 1ns / 1ps
module gray_png_stored_stream_writer_tb;
  import gpsw_pkg::*;

  localparam bit [2:0] ADDR_WIDTH = 3'd0;
  localparam bit [2:0] ADDR_HEIGHT = 3'd4;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    byte_t data;
    bit    last;
    bit    fin;
  } png_beat_t;

  class png_scoreboard;
    bit [15:0]  reg_w = 16'd1;
    bit [15:0]  reg_h = 16'd1;
    bit [16:0]  img_w = 17'd1;
    bit [16:0]  img_h = 17'd1;
    bit [16:0]  col;
    bit [15:0]  row;
    bit [15:0]  blk_left;
    bit [32:0]  data_count;
    bit [16:0]  ad_lo = 17'd1;
    bit [16:0]  ad_hi;
    bit [31:0]  crc = 32'hFFFF_FFFF;
    bit         in_image;
    byte_t      held[$];
    bit         held_end;
    byte_t      work[$];
    png_beat_t  pending[$];
    int         errors;

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void push_byte(byte_t b);
      bit [31:0] c;
      c = crc ^ {24'b0, b};
      for (int i = 0; i < 8; i++) c = c[0] ? (c >> 1) ^ 32'hEDB88320 : c >> 1;
      crc = c;
      work.push_back(b);
    endfunction

    function void push_word(bit [31:0] v);
      for (int i = 3; i >= 0; i--) push_byte(v[8*i +: 8]);
    endfunction

    function void push_tag(bit [31:0] t);
      crc = 32'hFFFF_FFFF;
      push_word(t);
    endfunction

    function bit [32:0] raw_len();
      return (img_w + 33'd1) * img_h;
    endfunction

    function void open_image();
      byte_t sig[8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
      longint unsigned nblk, idat;
      img_w = (reg_w == 0) ? 17'd1 : {1'b0, reg_w};
      img_h = (reg_h == 0) ? 17'd1 : {1'b0, reg_h};
      col = 0;
      row = 0;
      blk_left = 0;
      data_count = 0;
      ad_lo = 1;
      ad_hi = 0;
      foreach (sig[i]) push_byte(sig[i]);
      push_word(32'd13);
      push_tag(32'h49484452);
      push_word({15'b0, img_w});
      push_word({15'b0, img_h});
      push_byte(8'd8);
      repeat (4) push_byte(8'd0);
      push_word(~crc);
      nblk = (raw_len() + 64'd65534) / 64'd65535;
      idat = 64'd6 + 64'd5 * nblk + raw_len();
      push_word(idat[31:0]);
      push_tag(32'h49444154);
      push_byte(8'h78);
      push_byte(8'h01);
      in_image = 1;
    endfunction

    function void push_data(byte_t b);
      bit [32:0] rest;
      bit [15:0] len;
      if (blk_left == 0) begin
        rest = raw_len() - data_count;
        len = (rest > 33'd65535) ? 16'hFFFF : rest[15:0];
        push_byte((rest <= 33'd65535) ? 8'd1 : 8'd0);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        push_byte(~len[7:0]);
        push_byte(~len[15:8]);
        blk_left = len;
      end
      push_byte(b);
      blk_left--;
      data_count++;
      ad_lo = ad_lo + b;
      if (ad_lo >= 17'd65521) ad_lo -= 17'd65521;
      ad_hi = ad_hi + ad_lo;
      if (ad_hi >= 17'd65521) ad_hi -= 17'd65521;
    endfunction

    function void close_image();
      push_word({ad_hi[15:0], ad_lo[15:0]});
      push_word(~crc);
      push_word(32'd0);
      push_tag(32'h49454E44);
      push_word(~crc);
      in_image = 0;
    endfunction

    function void note_pixel(byte_t px);
      bit end_tail;
      int n;
      end_tail = held_end;
      work = held;
      held.delete();
      held_end = 0;
      if (in_image || !end_tail) begin
        if (!in_image) open_image();
        if (col == 0) begin
          push_data(8'd0);
          col = 1;
        end
        push_data(px);
        col++;
        if (col == img_w + 17'd1) begin
          col = 0;
          row++;
          if (row >= img_h) begin
            close_image();
            end_tail = 1;
          end
        end
      end
      n = (work.size() > STEP_MAX) ? STEP_MAX : work.size();
      for (int k = 0; k < n; k++)
        pending.push_back('{work[k], k + 1 == n, end_tail && (k + 1 == work.size())});
      for (int k = n; k < work.size(); k++) held.push_back(work[k]);
      if (held.size() > 0) held_end = end_tail;
    endfunction

    task check_beat(byte_t data, bit last, bit fin);
      png_beat_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected byte beat 0x%02h", data));
        return;
      end
      e = pending.pop_front();
      if (data !== e.data) report($sformatf("out_byte 0x%02h, want 0x%02h", data, e.data));
      if (last !== e.last) report($sformatf("run_last %b, want %b", last, e.last));
      if (fin !== e.fin) report($sformatf("file_end %b, want %b", fin, e.fin));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gpsw_pixel_if pix_if();
  gpsw_byte_if byte_if();

  png_scoreboard sb = new();
  bit calm;
  int hold;
  int idle_cycles;
  int pixels_sent;

  gray_png_stored_stream_writer uut (
    .clk(clk), .rst(rst), .pix(pix_if), .bytes(byte_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    byte_if.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (calm) begin
      byte_if.ready <= 1'b1;
    end else if (hold > 0) begin
      byte_if.ready <= 1'b0;
      hold <= hold - 1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:74]: byte_if.ready <= 1'b1;
        [75:96]: begin
          byte_if.ready <= 1'b0;
          hold <= $urandom_range(0, 2);
        end
        default: begin
          byte_if.ready <= 1'b0;
          hold <= $urandom_range(10, 40);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_if.valid && byte_if.ready)
      sb.check_beat(byte_if.out_byte, byte_if.run_last, byte_if.file_end);
    if ((byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    if (calm) return 0;
    case ($urandom_range(0, 99)) inside
      [0:59]: return 0;
      [60:91]: return $urandom_range(1, 3);
      default: return $urandom_range(5, 40);
    endcase
  endfunction

  task automatic send_pixel(byte_t px);
    int g;
    g = pick_gap();
    if (g > 0) begin
      pix_if.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    pix_if.valid = 1'b1;
    pix_if.pixel = px;
    do @(posedge clk); while (!pix_if.ready);
    sb.note_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    pix_if.valid = 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(bit [2:0] addr, bit [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_WIDTH) sb.reg_w = data[15:0];
    else sb.reg_h = data[15:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic flush_tail();
    while (sb.held.size() > 0) send_pixel(byte_t'($urandom_range(0, 255)));
  endtask

  task automatic run_image(int w, int h, int n);
    settle();
    apb_write(ADDR_WIDTH, w);
    apb_write(ADDR_HEIGHT, h);
    repeat (n) send_pixel(byte_t'($urandom_range(0, 255)));
    flush_tail();
  endtask

  initial begin
    int w, h;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_pixel(8'h00);
    flush_tail();
    settle();
    apb_write(ADDR_WIDTH, 4);
    apb_write(ADDR_HEIGHT, 2);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h55);
    settle();
    apb_write(ADDR_WIDTH, 7);
    apb_write(ADDR_HEIGHT, 3);
    send_pixel(8'hAA);
    repeat (4) send_pixel(byte_t'($urandom_range(0, 255)));
    flush_tail();
    run_image(7, 3, 21);
    run_image(0, 0, 1);
    run_image(1, 3, 3);

    while (pixels_sent < 500) begin
      calm = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(25, 200);
        h = 1;
      end else begin
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 5);
      end
      run_image(w, h, w * h);
    end

    calm = 1'b0;
    run_image(65535, 65535, 3);

    settle();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
